@@ rtl/lbp_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_pkg
// Shared types for the LSB-first bit packer: word layouts, controller state,
// and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package lbp_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 6;
   localparam int BYTE_W  = 8;
   localparam int TOTAL_W = 32;
   // pending bits (up to 7) plus a full field
   localparam int ACC_W   = DATA_W + BYTE_W;
   // results per item, at most five
   localparam int LEFT_W  = 3;

   typedef struct packed {
      logic [DATA_W-1:0]  data_bits;
      logic [COUNT_W-1:0] bit_count;
      logic               flush;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic [TOTAL_W-1:0] bits_total;
      logic               last;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cmd_type;

   typedef struct packed {
      logic has_result;
      logic last;
   } sts_type;

endpackage
`default_nettype wire

@@ rtl/lbp_datapath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_datapath
// Holds the partial byte, bit position and running bit total, and an
// accumulator that shifts out one finished byte per step.
// ---------------------------------------------------------------------------
module lbp_datapath #(
   parameter int MAX_FIELD_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lbp_pkg::req_type req_data,
   input  wire lbp_pkg::cmd_type cmd,
   output lbp_pkg::sts_type      sts,
   output lbp_pkg::rsp_type      rsp_data
);
   import lbp_pkg::*;

   localparam int LIMIT = (MAX_FIELD_BITS > DATA_W) ? DATA_W : MAX_FIELD_BITS;
   localparam logic [COUNT_W-1:0] LIMIT_CNT = COUNT_W'(LIMIT);

   logic [BYTE_W-1:0]  partial_ff, partial_in;
   logic [2:0]         pos_ff, pos_in;
   logic [TOTAL_W-1:0] written_ff, written_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [LEFT_W-1:0]  left_ff, left_in;

   logic [COUNT_W-1:0] cnt_sat;
   logic [63:0]        mask_wide;
   logic [DATA_W-1:0]  data_masked;
   logic [ACC_W-1:0]   merged;
   logic [ACC_W-1:0]   rest;
   logic [COUNT_W-1:0] total;
   logic [2:0]         full_bytes;
   logic               tail;
   logic [LEFT_W-1:0]  n_results;

   always_comb begin
      cnt_sat     = (req_data.bit_count > LIMIT_CNT) ? LIMIT_CNT : req_data.bit_count;
      mask_wide   = (64'd1 << cnt_sat) - 64'd1;
      data_masked = req_data.data_bits & mask_wide[DATA_W-1:0];
      merged      = ({{BYTE_W{1'b0}}, data_masked} << pos_ff)
                    | {{DATA_W{1'b0}}, partial_ff};
      total       = {{(COUNT_W-3){1'b0}}, pos_ff} + cnt_sat;
      full_bytes  = total[COUNT_W-1:3];
      tail        = req_data.flush && (total[2:0] != 3'd0);
      n_results   = full_bytes + {{(LEFT_W-1){1'b0}}, tail};
      // leftover bits after the full bytes
      rest        = merged >> {full_bytes, 3'b000};
   end

   always_comb begin
      partial_in = partial_ff;
      pos_in     = pos_ff;
      written_in = written_ff;
      acc_in     = acc_ff;
      left_in    = left_ff;
      if (cmd.load) begin
         acc_in     = merged;
         left_in    = n_results;
         written_in = written_ff + {{(TOTAL_W-COUNT_W){1'b0}}, cnt_sat};
         if (tail || total[2:0] == 3'd0) begin
            partial_in = '0;
            pos_in     = '0;
         end else begin
            partial_in = rest[BYTE_W-1:0];
            pos_in     = total[2:0];
         end
      end else if (cmd.shift) begin
         acc_in  = acc_ff >> BYTE_W;
         left_in = left_ff - {{(LEFT_W-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pos_ff     <= '0;
         written_ff <= '0;
         left_ff    <= '0;
      end else begin
         partial_ff <= partial_in;
         pos_ff     <= pos_in;
         written_ff <= written_in;
         left_ff    <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign sts.has_result = (n_results != '0);
   assign sts.last       = (left_ff == LEFT_W'(1));

   assign rsp_data.out_byte   = acc_ff[BYTE_W-1:0];
   assign rsp_data.bits_total = written_ff;
   assign rsp_data.last       = sts.last;

endmodule
`default_nettype wire

@@ rtl/lbp_controller.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lbp_controller
// Sequences one word at a time: load it into the datapath, then hand out
// its bytes one per accepted response.
// ---------------------------------------------------------------------------
module lbp_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire lbp_pkg::sts_type sts,
   output lbp_pkg::cmd_type      cmd
);
   import lbp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // skip emit when the word completes no byte
               if (sts.has_result) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.shift = 1'b1;
               if (sts.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/lsb_first_bit_packer.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lsb_first_bit_packer
// Packs fields of 0 to 32 bits into a byte stream, least significant bit
// first, with optional zero-padded flush of the partial byte.
// ---------------------------------------------------------------------------
// Channel  Dir  Handshake             Word
// req      in   req_valid/req_ready   data_bits, bit_count, flush
// rsp      out  rsp_valid/rsp_ready   out_byte, bits_total, last
//
// A word is loaded, then yields its bytes (0 to 5), one per accepted rsp;
// the byte count is set at load from the bit position, field width and flush.
// A word that yields no byte is done in its load cycle.
// Reset clears the partial byte, bit position, bit total and controller.
// A stalled rsp holds the current byte; req_ready stays low until the last
// byte of the word is taken.
// ---------------------------------------------------------------------------
module lsb_first_bit_packer #(
   parameter int MAX_FIELD_BITS = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lbp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lbp_pkg::rsp_type      rsp_data
);
   import lbp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lbp_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lbp_datapath #(
      .MAX_FIELD_BITS (MAX_FIELD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
